// ----- rtl/core/per_branch_one_and_two_bit_predictor_defines.svh -----
// Assertion macros shared by the predictor RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef PER_BRANCH_ONE_AND_TWO_BIT_PREDICTOR_DEFINES_SVH
`define PER_BRANCH_ONE_AND_TWO_BIT_PREDICTOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define BPP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, disabled during reset
`define BPP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define BPP_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/bpp_pkg.sv -----
// Types and constants of the branch predictor.
// No dependencies; imported by every RTL file but the assertion macro header.
`default_nettype none

package bpp_pkg;

    localparam int unsigned TAG_W   = 20;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned WORD_W  = ADDR_W - 2;
    localparam int unsigned TOTAL_W = 32;

    localparam logic C_NOT_TAKEN = 1'b0;
    localparam logic C_TAKEN     = 1'b1;

    localparam logic [1:0] C_CTR_MIN        = 2'b00;
    localparam logic [1:0] C_CTR_WEAK_TAKEN = 2'b10;
    localparam logic [1:0] C_CTR_MAX        = 2'b11;

    typedef struct packed {
        logic [ADDR_W-1:0] branch_address;
        logic              taken;
    } t_branch;

    typedef struct packed {
        logic               one_bit_guess;
        logic               two_bit_guess;
        logic               one_bit_correct;
        logic               two_bit_correct;
        logic [TOTAL_W-1:0] one_bit_hit_total;
        logic [TOTAL_W-1:0] two_bit_hit_total;
        logic [TOTAL_W-1:0] branch_total;
    } t_result;

    // one table entry as stored in memory
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic             last;
        logic [1:0]       ctr;
    } t_entry;

    // per-branch prediction outcome
    typedef struct packed {
        logic one_guess;
        logic two_guess;
        logic one_ok;
        logic two_ok;
    } t_verdict;

endpackage

`default_nettype wire

// ----- rtl/core/bpp_branch_if.sv -----
// Valid/ready channel carrying resolved branches.
// Depends on bpp_pkg.
`default_nettype none

interface bpp_branch_if;
    import bpp_pkg::*;

    logic    valid;
    logic    ready;
    t_branch data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bpp_result_if.sv -----
// Valid/ready channel carrying prediction results.
// Depends on bpp_pkg.
`default_nettype none

interface bpp_result_if;
    import bpp_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/per_branch_one_and_two_bit_predictor.sv -----
// Top level of the per-branch one-bit / two-bit predictor.
// Depends on bpp_pkg, both channel interfaces, bpp_table, bpp_predict,
// bpp_result and the assertion macro header.
//
//   i_branch takes one resolved branch per transaction (byte address and
//   taken outcome); o_result returns exactly one result per branch, in
//   order: both predictions made before the update, whether each was
//   right, and saturating totals of branches and hits.
//   Path: an accepted branch is held in the lookup stage register, then
//   its result moves to the output register that drives o_result.
//   Throughput: one branch per cycle unless o_result is held. The table RAM
//   is read at accept; the read-modify-write completes as the branch leaves
//   lookup. A forwarding register covers a read of the entry its predecessor is writing.
//   Reset: totals clear, and a clearing sweep then writes every table entry
//   invalid, one per cycle; i_branch.ready stays low during the sweep.
//   Stall: when o_result is held, the lookup stage holds its branch and
//   i_branch.ready drops until the output register frees up; nothing is
//   lost or repeated.
//   TABLE_ENTRIES must be a power of two in 16..65536.
`default_nettype none
`include "per_branch_one_and_two_bit_predictor_defines.svh"

module per_branch_one_and_two_bit_predictor #(
    parameter int unsigned TABLE_ENTRIES = 1024
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    bpp_branch_if.sink      i_branch,
    bpp_result_if.source    o_result
);
    import bpp_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

    // address split: drop byte offset, low bits index, next bits tag
    logic [WORD_W-1:0]  in_word;
    logic [WORD_W-1:0]  in_word_hi;
    logic [IDX_W-1:0]   in_idx;
    logic [TAG_W-1:0]   in_tag;

    logic               accept;
    logic               b_adv;
    logic               can_take;
    logic               tbl_busy;

    // lookup stage
    logic               r_b_valid;
    logic [IDX_W-1:0]   r_b_idx;
    logic [TAG_W-1:0]   r_b_tag;
    logic               r_b_taken;

    // last write, forwarded to a read that raced it
    logic               r_fw_valid;
    logic [IDX_W-1:0]   r_fw_idx;
    t_entry             r_fw_entry;

    t_entry             rd_entry;
    t_entry             cur_entry;
    t_entry             new_entry;
    t_verdict           verdict;

    assign in_word    = i_branch.data.branch_address[ADDR_W-1:2];
    assign in_word_hi = in_word >> IDX_W;
    assign in_idx     = in_word[IDX_W-1:0];
    assign in_tag     = in_word_hi[TAG_W-1:0];

    assign i_branch.ready = !tbl_busy && (!r_b_valid || can_take);
    assign accept         = i_branch.valid && i_branch.ready;
    assign b_adv          = r_b_valid && can_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_fw_valid <= 1'b1;
            end
        end
    end

    // payload of the lookup stage and the forwarding register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_idx   <= in_idx;
            r_b_tag   <= in_tag;
            r_b_taken <= i_branch.data.taken;
        end
        if (b_adv) begin
            r_fw_idx   <= r_b_idx;
            r_fw_entry <= new_entry;
        end
    end

    bpp_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_idx  (in_idx),
        .o_rd_data (rd_entry),
        .i_wr_en   (b_adv),
        .i_wr_idx  (r_b_idx),
        .i_wr_data (new_entry),
        .o_busy    (tbl_busy)
    );

    // the RAM returns old data when read and written at the same edge
    assign cur_entry = (r_fw_valid && (r_fw_idx == r_b_idx)) ? r_fw_entry : rd_entry;

    bpp_predict u_predict (
        .i_entry   (cur_entry),
        .i_tag     (r_b_tag),
        .i_taken   (r_b_taken),
        .o_entry   (new_entry),
        .o_verdict (verdict)
    );

    bpp_result u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (b_adv),
        .i_verdict  (verdict),
        .o_can_take (can_take),
        .o_result   (o_result)
    );

    `BPP_ASSERT_IMP(a_no_accept_in_sweep, i_clk, i_rst_n, tbl_busy, !accept && !r_b_valid)
    `BPP_ASSERT_NXT(a_lookup_holds, i_clk, i_rst_n, r_b_valid && !can_take,
        r_b_valid && $stable(r_b_idx) && $stable(r_b_tag) && $stable(r_b_taken))
    `BPP_ASSERT_NXT(a_advance_shows_result, i_clk, i_rst_n, b_adv, o_result.valid)

endmodule

`default_nettype wire

// ----- rtl/core/bpp_table.sv -----
// Predictor table: one synchronous RAM with registered read and a
// clearing sweep after reset. Depends on bpp_pkg.
`default_nettype none

module bpp_table #(
    parameter int unsigned TABLE_ENTRIES = 1024
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_rd_en,
    input  wire  [$clog2(TABLE_ENTRIES)-1:0]    i_rd_idx,
    output bpp_pkg::t_entry                     o_rd_data,
    input  wire                                 i_wr_en,
    input  wire  [$clog2(TABLE_ENTRIES)-1:0]    i_wr_idx,
    input  bpp_pkg::t_entry                     i_wr_data,
    output logic                                o_busy
);
    import bpp_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

    t_entry             mem [TABLE_ENTRIES];
    t_entry             r_rd_data;
    logic               r_clearing;
    logic [IDX_W-1:0]   r_clr_idx;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    t_entry             wr_data;

    // sweep owns the write port until every entry reads as invalid
    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_idx  = r_clr_idx;
            wr_data = '0;
        end else begin
            wr_en   = i_wr_en;
            wr_idx  = i_wr_idx;
            wr_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == {IDX_W{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clearing;

endmodule

`default_nettype wire

// ----- rtl/core/bpp_predict.sv -----
// Lookup, predict and update of one table entry.
// Depends on bpp_pkg.
`default_nettype none

module bpp_predict (
    input  bpp_pkg::t_entry                 i_entry,
    input  wire  [bpp_pkg::TAG_W-1:0]       i_tag,
    input  wire                             i_taken,
    output bpp_pkg::t_entry                 o_entry,
    output bpp_pkg::t_verdict               o_verdict
);
    import bpp_pkg::*;

    logic       hit;
    t_entry     cur;
    logic [1:0] ctr_next;

    always_comb begin
        hit = i_entry.valid && (i_entry.tag == i_tag);

        // miss: allocate a fresh entry and predict from it
        if (hit) begin
            cur = i_entry;
        end else begin
            cur.valid = 1'b1;
            cur.tag   = i_tag;
            cur.last  = C_NOT_TAKEN;
            cur.ctr   = C_CTR_WEAK_TAKEN;
        end

        o_verdict.one_guess = cur.last;
        o_verdict.two_guess = cur.ctr[1];
        o_verdict.one_ok    = (cur.last == i_taken);
        o_verdict.two_ok    = (cur.ctr[1] == i_taken);

        if (i_taken == C_TAKEN) begin
            ctr_next = (cur.ctr == C_CTR_MAX) ? cur.ctr : cur.ctr + 2'd1;
        end else begin
            ctr_next = (cur.ctr == C_CTR_MIN) ? cur.ctr : cur.ctr - 2'd1;
        end

        o_entry.valid = 1'b1;
        o_entry.tag   = i_tag;
        o_entry.last  = i_taken;
        o_entry.ctr   = ctr_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/bpp_result.sv -----
// Output register with saturating branch and hit totals.
// Depends on bpp_pkg, bpp_result_if and the assertion macro header.
`default_nettype none
`include "per_branch_one_and_two_bit_predictor_defines.svh"

module bpp_result (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_rec,
    input  bpp_pkg::t_verdict   i_verdict,
    output logic                o_can_take,
    bpp_result_if.source        o_result
);
    import bpp_pkg::*;

    logic               r_valid;
    t_verdict           r_verdict;
    logic [TOTAL_W-1:0] r_one_hits;
    logic [TOTAL_W-1:0] r_two_hits;
    logic [TOTAL_W-1:0] r_branches;

    assign o_can_take = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_one_hits <= '0;
            r_two_hits <= '0;
            r_branches <= '0;
        end else begin
            if (i_rec) begin
                r_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
            // totals hold at all ones
            if (i_rec && !(&r_branches)) begin
                r_branches <= r_branches + 1'b1;
            end
            if (i_rec && i_verdict.one_ok && !(&r_one_hits)) begin
                r_one_hits <= r_one_hits + 1'b1;
            end
            if (i_rec && i_verdict.two_ok && !(&r_two_hits)) begin
                r_two_hits <= r_two_hits + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rec) begin
            r_verdict <= i_verdict;
        end
    end

    assign o_result.valid                  = r_valid;
    assign o_result.data.one_bit_guess     = r_verdict.one_guess;
    assign o_result.data.two_bit_guess     = r_verdict.two_guess;
    assign o_result.data.one_bit_correct   = r_verdict.one_ok;
    assign o_result.data.two_bit_correct   = r_verdict.two_ok;
    assign o_result.data.one_bit_hit_total = r_one_hits;
    assign o_result.data.two_bit_hit_total = r_two_hits;
    assign o_result.data.branch_total      = r_branches;

    `BPP_ASSERT_IMP(a_hits_bounded, i_clk, i_rst_n, 1'b1,
        r_one_hits <= r_branches && r_two_hits <= r_branches)
    `BPP_ASSERT_NXT(a_branch_count_step, i_clk, i_rst_n, i_rec && !(&r_branches),
        r_branches == $past(r_branches) + 32'd1)
    `BPP_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_valid && !o_result.ready, !i_rec)

endmodule

`default_nettype wire
